/* src/gfdi_pkg.sv */
// shared types and constants of the gyro frame deframer and integrator
`default_nettype none
package gfdi_pkg;

   localparam int unsigned FRAME_LEN = 18;
   localparam int unsigned STORE_LEN = FRAME_LEN - 1;
   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   localparam int unsigned RATE_W = 16;
   localparam int unsigned PROD_W = 32;
   localparam int unsigned OUT_SUM_W = 64;
   localparam int unsigned TICK_W = 48;
   localparam int unsigned RSP_DATA_W = 336;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_HEADER   = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } frame_status_type;

endpackage
`default_nettype wire

/* src/gyro_frame_deframer_integrator_unit.sv */
// Rate-gyro frame deframer and integrator: 18-byte frames in, one result per frame out.
//
// req_* is a byte stream (tdata[7:0] = rx_byte); framing rests on the byte count
// alone, byte 0 must be 0xFF and byte 17 is the 8-bit sum of bytes 0..16.
// rsp_* carries one item per frame: tuser = frame_status, tdata = decoded rates,
// temperature, tick stamp, elapsed ticks of this frame and the running saturated
// sums of rate times ticks for each axis plus the tick total.
// One byte is taken every cycle while req_tready is high. Bytes 0..16 go into a
// byte store and a running checksum. The last byte of a frame enters a
// three-register path: decode and delta, then the three 16x17 multipliers, then
// the saturating accumulators and the result register.
// Only one result is in flight: the last byte of the next frame waits while an
// earlier result is still in the path or not yet taken by the receiver; the
// other bytes of that frame are still taken meanwhile.
// Reset clears the byte count, checksum, first-frame flag, stamp, sums and
// the tick total; the byte store holds no reset value.
`default_nettype none
module gyro_frame_deframer_integrator_unit
   import gfdi_pkg::*;
#(
   parameter int unsigned SUM_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] rx_byte
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // roll_rate, pitch_rate, yaw_rate, temp_raw,
                                                   // tick_stamp, delta_ticks, roll_angle_sum,
                                                   // pitch_angle_sum, yaw_angle_sum, elapsed_ticks
   output      logic [1:0]            rsp_tuser    // [1:0] frame_status
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0] csum_ff, csum_in;
   logic [7:0] frame_ff [STORE_LEN];
   logic first_ff, first_in;
   logic [15:0] prev_ff, prev_in;

   logic s1_valid_ff;
   frame_status_type s1_status_ff, status_in;
   logic signed [RATE_W-1:0] s1_rate_ff [3];
   logic [15:0] s1_temp_ff, s1_stamp_ff, s1_delta_ff, delta_in, stamp_in;

   logic s2_valid_ff;
   frame_status_type s2_status_ff;
   logic signed [RATE_W-1:0] s2_rate_ff [3];
   logic [15:0] s2_temp_ff, s2_stamp_ff, s2_delta_ff;
   logic signed [PROD_W-1:0] s2_prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [16:0] delta_s;

   logic out_valid_ff, out_valid_in;
   frame_status_type out_status_ff;
   logic [15:0] out_rate_ff [3];
   logic [15:0] out_temp_ff, out_stamp_ff, out_delta_ff;

   logic signed [SUM_WIDTH-1:0] sums_ff [3];
   logic signed [SUM_WIDTH-1:0] sums_in [3];
   logic signed [SUM_WIDTH:0] wide [3];
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W:0] tick_sum;

   logic signed [OUT_SUM_W-1:0] sum_out [3];

   logic req_fire, last_byte, rsp_busy;

   assign last_byte = (pos_ff == LAST_POS);
   assign rsp_busy = s1_valid_ff || s2_valid_ff || (out_valid_ff && !rsp_tready);
   assign req_tready = !last_byte || !rsp_busy;
   assign req_fire = req_tvalid && req_tready;

   // byte count, checksum and frame end decode
   always_comb begin
      pos_in = pos_ff;
      csum_in = csum_ff;
      first_in = first_ff;
      prev_in = prev_ff;
      stamp_in = {frame_ff[15], frame_ff[16]};
      if (frame_ff[0] != HEADER_BYTE) begin
         status_in = STATUS_HEADER;
      end else if (req_tdata != csum_ff) begin
         status_in = STATUS_CHECKSUM;
      end else begin
         status_in = STATUS_OK;
      end
      delta_in = '0;
      if (status_in == STATUS_OK && !first_ff) begin
         delta_in = prev_ff - stamp_in;
      end
      if (req_fire) begin
         if (last_byte) begin
            pos_in = '0;
            csum_in = '0;
            if (status_in == STATUS_OK) begin
               first_in = 1'b0;
               prev_in = stamp_in;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
            csum_in = csum_ff + req_tdata;
         end
      end
   end

   // products and saturating accumulation
   assign delta_s = signed'({1'b0, s1_delta_ff});

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod_in[a] = s1_rate_ff[a] * delta_s;
         wide[a] = (SUM_WIDTH + 1)'(sums_ff[a]) + (SUM_WIDTH + 1)'(s2_prod_ff[a]);
         if (wide[a][SUM_WIDTH] != wide[a][SUM_WIDTH-1]) begin
            sums_in[a] = wide[a][SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                            : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
         end else begin
            sums_in[a] = wide[a][SUM_WIDTH-1:0];
         end
         sum_out[a] = OUT_SUM_W'(sums_ff[a]);
      end
      tick_sum = {1'b0, tick_ff} + (TICK_W + 1)'(s2_delta_ff);
      tick_in = tick_sum[TICK_W] ? '1 : tick_sum[TICK_W-1:0];
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s2_valid_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         csum_ff <= '0;
         first_ff <= 1'b1;
         prev_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         tick_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            sums_ff[a] <= '0;
         end
      end else begin
         pos_ff <= pos_in;
         csum_ff <= csum_in;
         first_ff <= first_in;
         prev_ff <= prev_in;
         s1_valid_ff <= req_fire && last_byte;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
         if (s2_valid_ff) begin
            tick_ff <= tick_in;
            for (int a = 0; a < 3; a++) begin
               sums_ff[a] <= sums_in[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !last_byte) begin
         frame_ff[pos_ff] <= req_tdata;
      end
      if (req_fire && last_byte) begin
         s1_status_ff <= status_in;
         s1_rate_ff[0] <= signed'({frame_ff[1], frame_ff[2]});
         s1_rate_ff[1] <= signed'({frame_ff[3], frame_ff[4]});
         s1_rate_ff[2] <= signed'({frame_ff[5], frame_ff[6]});
         s1_temp_ff <= {frame_ff[13], frame_ff[14]};
         s1_stamp_ff <= stamp_in;
         s1_delta_ff <= delta_in;
      end
      if (s1_valid_ff) begin
         s2_status_ff <= s1_status_ff;
         s2_temp_ff <= s1_temp_ff;
         s2_stamp_ff <= s1_stamp_ff;
         s2_delta_ff <= s1_delta_ff;
         for (int a = 0; a < 3; a++) begin
            s2_rate_ff[a] <= s1_rate_ff[a];
            s2_prod_ff[a] <= prod_in[a];
         end
      end
      if (s2_valid_ff) begin
         out_status_ff <= s2_status_ff;
         out_temp_ff <= s2_temp_ff;
         out_stamp_ff <= s2_stamp_ff;
         out_delta_ff <= s2_delta_ff;
         for (int a = 0; a < 3; a++) begin
            out_rate_ff[a] <= s2_rate_ff[a];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_status_ff;
   assign rsp_tdata = {tick_ff, sum_out[2], sum_out[1], sum_out[0], out_delta_ff,
                       out_stamp_ff, out_temp_ff, out_rate_ff[2], out_rate_ff[1],
                       out_rate_ff[0]};

endmodule
`default_nettype wire

/* src/gfdi_checker.sv */
// port-level checks of the gyro frame deframer and integrator
`default_nettype none
module gfdi_checker
   import gfdi_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item right after reset");

   // bad frames add no ticks
   a_bad_no_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[95:80] == 16'd0)
      else $error("bad frame reports elapsed ticks");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_HEADER ||
                     rsp_tuser == STATUS_CHECKSUM)
      else $error("undefined frame status");

   // tick total never drops while a result is held
   a_tick_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tdata[335:288] >= $past(rsp_tdata[335:288]))
      else $error("tick total went down");

endmodule

bind gyro_frame_deframer_integrator_unit gfdi_checker u_gfdi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* verif/gyro_frame_deframer_integrator_unit_tb.sv */
// self-checking testbench of the gyro frame deframer and integrator with a byte-level predictor
module gyro_frame_deframer_integrator_unit_tb;
   import gfdi_pkg::*;

   localparam int unsigned SUM_W = 64;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned RANDOM_BYTES = 1900;
   localparam int unsigned NUM_FIELDS = 10;
   localparam int unsigned NUM_ROWS = 9;

   typedef struct {
      frame_status_type      status;
      logic [RSP_DATA_W-1:0] data;
   } frame_result_t;

   typedef struct packed {
      logic [7:0]       hdr;
      logic [15:0]      roll;
      logic [15:0]      pitch;
      logic [15:0]      yaw;
      logic [15:0]      temp;
      logic [15:0]      stamp;
      bit               bad_sum;
      frame_status_type status;
   } frame_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   bit          burst_mode = 1'b0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   logic [15:0] stamp_cursor;

   // predictor state
   logic [7:0]        rx_store [STORE_LEN];
   logic [POS_W-1:0]  rx_count = '0;
   logic [7:0]        rx_sum = '0;
   bit                first_frame = 1'b1;
   logic [15:0]       last_stamp = '0;
   longint            axis_total [3] = '{0, 0, 0};
   logic [TICK_W-1:0] tick_total = '0;
   frame_result_t     expected_frames [$];

   int    field_lsb [NUM_FIELDS] = '{0, 16, 32, 48, 64, 80, 96, 160, 224, 288};
   int    field_width [NUM_FIELDS] = '{16, 16, 16, 16, 16, 16, 64, 64, 64, 48};
   string field_name [NUM_FIELDS] = '{"roll_rate", "pitch_rate", "yaw_rate", "temp_raw",
                                      "tick_stamp", "delta_ticks", "roll_angle_sum",
                                      "pitch_angle_sum", "yaw_angle_sum", "elapsed_ticks"};

   frame_row_t directed_frames [NUM_ROWS] = '{
      '{8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 1'b0, STATUS_OK},
      '{8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0FF0, 1'b0, STATUS_OK},
      '{8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'h0042, 16'h0100, 1'b0, STATUS_HEADER},
      '{8'hFF, 16'h4321, 16'hEDCB, 16'h0001, 16'h0043, 16'h0200, 1'b1, STATUS_CHECKSUM},
      '{8'h7F, 16'hAAAA, 16'h5555, 16'h8001, 16'h0044, 16'h0300, 1'b1, STATUS_HEADER},
      '{8'hFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h1234, 16'h0FF0, 1'b0, STATUS_OK},
      '{8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hFFF0, 1'b0, STATUS_OK},
      '{8'hFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hAAAA, 16'hFFF1, 1'b0, STATUS_OK},
      '{8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, STATUS_OK}
   };

   gyro_frame_deframer_integrator_unit #(
      .SUM_WIDTH(SUM_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint clamp_sum(input longint s, input longint p);
      logic signed [65:0] w;
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = (66'sd1 <<< (SUM_W - 1)) - 66'sd1;
      lo = -hi - 66'sd1;
      w = s;
      w = w + p;
      if (w > hi) begin
         w = hi;
      end else if (w < lo) begin
         w = lo;
      end
      return w[63:0];
   endfunction

   function automatic void track_rx_byte(input logic [7:0] b);
      frame_result_t      r;
      logic signed [15:0] rate [3];
      logic [15:0]        temp;
      logic [15:0]        stamp;
      logic [15:0]        delta;
      logic [TICK_W:0]    ticks;
      if (rx_count < LAST_POS) begin
         rx_store[rx_count] = b;
         rx_sum = rx_sum + b;
         rx_count = rx_count + 1'b1;
         return;
      end
      delta = '0;
      rate[0] = {rx_store[1], rx_store[2]};
      rate[1] = {rx_store[3], rx_store[4]};
      rate[2] = {rx_store[5], rx_store[6]};
      temp = {rx_store[13], rx_store[14]};
      stamp = {rx_store[15], rx_store[16]};
      if (rx_store[0] != HEADER_BYTE) begin
         r.status = STATUS_HEADER;
      end else if (b != rx_sum) begin
         r.status = STATUS_CHECKSUM;
      end else begin
         r.status = STATUS_OK;
      end
      if (r.status == STATUS_OK) begin
         if (first_frame) begin
            first_frame = 1'b0;
         end else begin
            delta = last_stamp - stamp;
            for (int a = 0; a < 3; a++) begin
               axis_total[a] = clamp_sum(axis_total[a], longint'(rate[a]) * longint'(delta));
            end
            ticks = {1'b0, tick_total} + delta;
            tick_total = ticks[TICK_W] ? '1 : ticks[TICK_W-1:0];
         end
         last_stamp = stamp;
      end
      rx_count = '0;
      rx_sum = '0;
      r.data = {tick_total, axis_total[2], axis_total[1], axis_total[0],
                delta, stamp, temp, rate[2], rate[1], rate[0]};
      expected_frames.push_back(r);
   endfunction

   function automatic void note_mismatch(input string what, input logic [63:0] exp_val,
                                         input logic [63:0] got_val);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %h, got %h", what, exp_val, got_val);
      end
   endfunction

   function automatic void check_frame_result(input logic [1:0] status,
                                              input logic [RSP_DATA_W-1:0] data);
      frame_result_t e;
      logic [63:0]   mask;
      logic [63:0]   exp_val;
      logic [63:0]   got_val;
      if (expected_frames.size() == 0) begin
         note_mismatch("unexpected item", '0, data[63:0]);
         return;
      end
      e = expected_frames.pop_front();
      if (status != e.status) begin
         note_mismatch("frame_status", 64'(e.status), 64'(status));
      end
      for (int f = 0; f < NUM_FIELDS; f++) begin
         mask = (64'd1 << field_width[f]) - 64'd1;
         exp_val = 64'(e.data >> field_lsb[f]) & mask;
         got_val = 64'(data >> field_lsb[f]) & mask;
         if (exp_val != got_val) begin
            note_mismatch(field_name[f], exp_val, got_val);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_frame_result(rsp_tuser, rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stall before each item
   initial begin
      int stall;
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] hdr, input logic [15:0] roll,
                             input logic [15:0] pitch, input logic [15:0] yaw,
                             input logic [15:0] temp, input logic [15:0] stamp,
                             input bit bad_sum);
      logic [7:0] frame [FRAME_LEN];
      logic [7:0] sum;
      frame[0] = hdr;
      {frame[1], frame[2]} = roll;
      {frame[3], frame[4]} = pitch;
      {frame[5], frame[6]} = yaw;
      for (int i = 7; i < 13; i++) begin
         frame[i] = 8'($urandom);
      end
      {frame[13], frame[14]} = temp;
      {frame[15], frame[16]} = stamp;
      sum = '0;
      for (int i = 0; i < STORE_LEN; i++) begin
         sum = sum + frame[i];
      end
      frame[FRAME_LEN-1] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < FRAME_LEN; i++) begin
         push_byte(frame[i]);
      end
   endtask

   function automatic logic [15:0] pick_rate();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_frames.size() != 0);
   endtask

   initial begin
      int          kind;
      int unsigned frame_index;
      logic [7:0]  hdr;
      logic [15:0] stamp;
      bit          bad_sum;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         send_frame(directed_frames[r].hdr, directed_frames[r].roll, directed_frames[r].pitch,
                    directed_frames[r].yaw, directed_frames[r].temp,
                    directed_frames[r].stamp, directed_frames[r].bad_sum);
         if (expected_frames.size() == 0 ||
             expected_frames[$].status != directed_frames[r].status) begin
            note_mismatch("directed frame_status", 64'(directed_frames[r].status), '0);
         end
      end
      drain_results();

      stamp_cursor = 16'($urandom);
      frame_index = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 6) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
               push_byte(8'($urandom));
            end
         end else begin
            hdr = (kind < 12) ? 8'($urandom_range(0, 254)) : HEADER_BYTE;
            bad_sum = (kind >= 12 && kind < 20);
            if ($urandom_range(0, 9) == 0) begin
               stamp = 16'($urandom);
            end else begin
               stamp = stamp_cursor - 16'($urandom_range(0, 3000));
            end
            stamp_cursor = stamp;
            send_frame(hdr, pick_rate(), pick_rate(), pick_rate(), 16'($urandom), stamp,
                       bad_sum);
         end
         frame_index++;
         if (frame_index == 50) begin
            drain_results();
         end
      end
      burst_mode = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
src/gfdi_pkg.sv
src/gyro_frame_deframer_integrator_unit.sv
src/gfdi_checker.sv
verif/gyro_frame_deframer_integrator_unit_tb.sv
